// File: src/cc3_pkg.sv
// Shared widths and constants of the circumcircle pipeline.
package cc3_pkg;

    localparam int CW      = 24;            // input coordinate width
    localparam int NPT     = 9;             // coordinates per transfer
    localparam int IN_W    = NPT * CW;
    localparam int DW      = 25;            // edge vector component
    localparam int XW      = 50;            // cross product component, signed
    localparam int XMW     = 49;            // cross product magnitude
    localparam int SQW     = 50;            // squared edge length
    localparam int DTW     = 51;            // dot product, signed
    localparam int DMW     = 50;            // dot product magnitude
    localparam int MUL_CH  = 16;            // multiplier chunk per stage
    localparam int MULB    = 50;            // narrow operand of every multiplier
    localparam int MUL_LAT = (MULB + MUL_CH - 1) / MUL_CH;
    localparam int N2W     = 100;           // squared norm of the cross product
    localparam int WW      = 100;           // barycentric weight numerator
    localparam int P01W    = 100;           // product of two squared lengths
    localparam int CPW     = 124;           // weight times coordinate
    localparam int CSW     = 127;           // signed center numerator
    localparam int CNW     = 126;           // center numerator magnitude
    localparam int RNW     = P01W + MULB;   // radius numerator
    localparam int RDW     = N2W + 2;       // radius denominator
    localparam int CDW     = N2W + 1;       // center denominator
    localparam int RQB     = 64;            // radius quotient bits
    localparam int CQB     = 32;            // center quotient bits
    localparam int SQ_W    = 64;            // square root operand
    localparam int OW      = 32;            // output field width
    localparam int OUT_W   = 4 * OW;

    localparam logic [OW-1:0] POS_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic [OW-1:0] NEG_MAG = {1'b1, {(OW-1){1'b0}}};
    localparam logic [OW-1:0] RAD_MAX = {OW{1'b1}};

endpackage

// File: src/cc3_dly.sv
// Delay line that keeps side values in step with the pipeline.
module cc3_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d_i,
    output logic [W-1:0] d_o
);

    logic [W-1:0] sh_reg [N];

    always_ff @(posedge aclk) begin
        if (en) begin
            sh_reg[0] <= d_i;
            for (int i = 1; i < N; i++) begin
                sh_reg[i] <= sh_reg[i-1];
            end
        end
    end

    assign d_o = sh_reg[N-1];

endmodule

// File: src/cc3_mul.sv
// Pipelined unsigned multiplier, one chunk of the narrow operand per stage.
module cc3_mul
    import cc3_pkg::*;
#(
    parameter int WA = MULB,
    parameter int WB = MULB
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [WA-1:0]      a_i,
    input  logic [WB-1:0]      b_i,
    output logic [WA+WB-1:0]   p_o
);

    localparam int NST = (WB + MUL_CH - 1) / MUL_CH;
    localparam int WBP = NST * MUL_CH;
    localparam int WP  = WA + WB;

    logic [WA-1:0]        a_reg   [NST-1];
    logic [WBP-1:0]       b_reg   [NST-1];
    logic [WP-1:0]        acc_reg [NST];
    logic [WA+MUL_CH-1:0] pp      [NST];
    logic [WBP-1:0]       b_pad;

    assign b_pad = WBP'(b_i);
    assign pp[0] = a_i * b_pad[MUL_CH-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg[0] <= WP'(pp[0]);
            a_reg[0]   <= a_i;
            b_reg[0]   <= b_pad;
        end
    end

    for (genvar k = 1; k < NST; k++) begin : g_st
        assign pp[k] = a_reg[k-1] * b_reg[k-1][k*MUL_CH +: MUL_CH];

        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[k] <= acc_reg[k-1] + (WP'(pp[k]) << (k * MUL_CH));
            end
        end

        if (k < NST - 1) begin : g_pass
            always_ff @(posedge aclk) begin
                if (en) begin
                    a_reg[k] <= a_reg[k-1];
                    b_reg[k] <= b_reg[k-1];
                end
            end
        end
    end

    assign p_o = acc_reg[NST-1];

endmodule

// File: src/cc3_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module cc3_div
    import cc3_pkg::*;
#(
    parameter int WN = RNW,
    parameter int WD = RDW,
    parameter int QB = RQB
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [WN-1:0] num_i,
    input  logic [WD-1:0] den_i,
    output logic [QB-1:0] q_o,
    output logic          over_o
);

    localparam int WR = WD + QB;
    localparam int WC = (WN > WR) ? WN : WR;

    logic [WR-1:0] rem_reg [QB];
    logic [WD-1:0] den_reg [QB];
    logic [QB-1:0] q_reg   [QB+1];
    logic          ovr_reg [QB+1];
    logic [WC-1:0] num_w;
    logic [WC-1:0] lim_w;

    // quotient does not fit when num >= den * 2^QB
    assign num_w = WC'(num_i);
    assign lim_w = WC'(den_i) << QB;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= WR'(num_i);
            den_reg[0] <= den_i;
            q_reg[0]   <= '0;
            ovr_reg[0] <= (num_w >= lim_w);
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_st
        localparam int SH = QB - j;
        logic [WR-1:0] trial;
        logic          ge;

        assign trial = WR'(den_reg[j-1]) << SH;
        assign ge    = (rem_reg[j-1] >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[j]   <= q_reg[j-1] | (QB'(ge) << SH);
                ovr_reg[j] <= ovr_reg[j-1];
            end
        end

        if (j < QB) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= ge ? (rem_reg[j-1] - trial) : rem_reg[j-1];
                    den_reg[j] <= den_reg[j-1];
                end
            end
        end
    end

    assign q_o    = q_reg[QB];
    assign over_o = ovr_reg[QB];

endmodule

// File: src/cc3_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module cc3_sqrt
    import cc3_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [SQ_W-1:0]   x_i,
    output logic [SQ_W/2-1:0] r_o
);

    localparam int NST = SQ_W / 2;

    logic [SQ_W-1:0] x_reg [NST-1];
    logic [SQ_W-1:0] r_reg [NST];

    for (genvar j = 0; j < NST; j++) begin : g_st
        localparam int SH = SQ_W - 2 - 2 * j;
        logic [SQ_W-1:0] xp;
        logic [SQ_W-1:0] rp;
        logic [SQ_W-1:0] t;
        logic            ge;

        if (j == 0) begin : g_first
            assign xp = x_i;
            assign rp = '0;
        end else begin : g_next
            assign xp = x_reg[j-1];
            assign rp = r_reg[j-1];
        end

        assign t  = rp + (SQ_W'(1) << SH);
        assign ge = (xp >= t);

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[j] <= ge ? ((rp >> 1) + (SQ_W'(1) << SH)) : (rp >> 1);
            end
        end

        if (j < NST - 1) begin : g_x
            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[j] <= ge ? (xp - t) : xp;
                end
            end
        end
    end

    assign r_o = r_reg[NST-1][SQ_W/2-1:0];

endmodule

// File: src/circumcircle_three_points_3d_top.sv
// Top level: circumradius and circumcenter of three 3D points, fully pipelined.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: p1 x,y,z  p2 x,y,z  p3 x,y,z
//  m_      | out | m_tvalid/m_tready  | m_tdata: radius, center x,y,z; m_tuser: degen
//
// One transfer is taken per cycle while m_ is not stalled; the pipeline holds
// 112 register stages: 4 front stages, two 4-stage multiplier ranks,
// 2 summing stages, 65 radius divider stages, 32 square root stages, output register.
// A stall on m_ freezes every stage at once; nothing is lost or repeated, and
// s_tready follows m_tready while a result is held.
// Reset clears only the valid bits; no clearing pass is needed.
module circumcircle_three_points_3d_top
    import cc3_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z (24 bits each)
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // radius, center_x, center_y, center_z (32 bits each)
    output logic [OUT_W-1:0] m_tdata,
    // degenerate
    output logic [0:0]       m_tuser
);

    // stage numbers of the pipeline registers
    localparam int ST_M1  = 3;
    localparam int ST_M1O = ST_M1 + MUL_LAT;
    localparam int ST_N2  = ST_M1O + 1;
    localparam int ST_M2O = ST_M1O + MUL_LAT;
    localparam int ST_SUM = ST_M2O + 1;
    localparam int ST_T   = ST_SUM + 1;
    localparam int ST_RD  = ST_T + RQB + 1;
    localparam int ST_SQ  = ST_RD + SQ_W / 2;
    localparam int ST_CD  = ST_T + CQB + 1;
    localparam int ST_CC  = ST_CD + 1;

    logic adv;
    logic [ST_SQ:0] vld_reg;
    logic           m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             m_tuser_reg;

    // advance the whole pipeline unless a held result blocks it
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= {vld_reg[ST_SQ-1:0], s_tvalid};
            m_tvalid_reg <= vld_reg[ST_SQ];
        end
    end

    // ---- stage 0: capture the points
    logic signed [CW-1:0] p0_reg [NPT];
    logic signed [CW-1:0] p1_reg [NPT];
    logic signed [CW-1:0] p2_reg [NPT];

    // ---- stage 1: edge vectors
    logic signed [DW-1:0] a_reg [3];
    logic signed [DW-1:0] b_reg [3];
    logic signed [DW-1:0] c_reg [3];
    logic signed [DW-1:0] a_next [3];
    logic signed [DW-1:0] b_next [3];
    logic signed [DW-1:0] c_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a_next[k] = DW'(p0_reg[k])     - DW'(p0_reg[3 + k]);
            b_next[k] = DW'(p0_reg[3 + k]) - DW'(p0_reg[6 + k]);
            c_next[k] = DW'(p0_reg[6 + k]) - DW'(p0_reg[k]);
        end
    end

    // ---- stage 2: cross product, squared lengths, dot products
    logic signed [XW-1:0]  xm [6];
    logic signed [XW-1:0]  cr_reg [3];
    logic [SQW-1:0]        sq_reg [3];
    logic signed [DTW-1:0] dot_reg [3];
    logic signed [51:0]    sqs [3];
    logic signed [51:0]    dts [3];

    assign xm[0] = a_reg[1] * b_reg[2];
    assign xm[1] = a_reg[2] * b_reg[1];
    assign xm[2] = a_reg[2] * b_reg[0];
    assign xm[3] = a_reg[0] * b_reg[2];
    assign xm[4] = a_reg[0] * b_reg[1];
    assign xm[5] = a_reg[1] * b_reg[0];

    assign sqs[0] = a_reg[0] * a_reg[0] + a_reg[1] * a_reg[1] + a_reg[2] * a_reg[2];
    assign sqs[1] = b_reg[0] * b_reg[0] + b_reg[1] * b_reg[1] + b_reg[2] * b_reg[2];
    assign sqs[2] = c_reg[0] * c_reg[0] + c_reg[1] * c_reg[1] + c_reg[2] * c_reg[2];

    assign dts[0] = -(a_reg[0] * c_reg[0] + a_reg[1] * c_reg[1] + a_reg[2] * c_reg[2]);
    assign dts[1] = -(a_reg[0] * b_reg[0] + a_reg[1] * b_reg[1] + a_reg[2] * b_reg[2]);
    assign dts[2] = -(c_reg[0] * b_reg[0] + c_reg[1] * b_reg[1] + c_reg[2] * b_reg[2]);

    // ---- stage 3: magnitudes and signs
    logic [XMW-1:0]      crm_reg [3];
    logic [DMW-1:0]      dm_reg [3];
    logic [2:0]          dneg_reg;
    logic [SQW-1:0]      sq3_reg [3];
    logic [NPT*CW-1:0]   pm_reg;
    logic [NPT-1:0]      pneg_reg;
    logic                dg_reg;
    logic [XW-1:0]       crm_w [3];
    logic [DTW-1:0]      dm_w [3];
    logic [CW-1:0]       pm_w [NPT];
    logic [NPT-1:0]      sg3;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            crm_w[k] = cr_reg[k][XW-1] ? XW'(-cr_reg[k]) : XW'(cr_reg[k]);
            dm_w[k]  = dot_reg[k][DTW-1] ? DTW'(-dot_reg[k]) : DTW'(dot_reg[k]);
        end
        for (int j = 0; j < NPT; j++) begin
            pm_w[j] = p2_reg[j][CW-1] ? CW'(-p2_reg[j]) : CW'(p2_reg[j]);
        end
        // sign of weight i times coordinate of point i
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                sg3[i*3 + k] = dneg_reg[i] ^ pneg_reg[i*3 + k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < NPT; j++) begin
                p0_reg[j]          <= s_tdata[j*CW +: CW];
                p1_reg[j]          <= p0_reg[j];
                p2_reg[j]          <= p1_reg[j];
                pm_reg[j*CW +: CW] <= pm_w[j];
                pneg_reg[j]        <= p2_reg[j][CW-1];
            end
            for (int k = 0; k < 3; k++) begin
                a_reg[k]    <= a_next[k];
                b_reg[k]    <= b_next[k];
                c_reg[k]    <= c_next[k];
                sq_reg[k]   <= sqs[k][SQW-1:0];
                dot_reg[k]  <= dts[k][DTW-1:0];
                crm_reg[k]  <= crm_w[k][XMW-1:0];
                dm_reg[k]   <= dm_w[k][DMW-1:0];
                dneg_reg[k] <= dot_reg[k][DTW-1];
                sq3_reg[k]  <= sq_reg[k];
            end
            cr_reg[0] <= xm[0] - xm[1];
            cr_reg[1] <= xm[2] - xm[3];
            cr_reg[2] <= xm[4] - xm[5];
            dg_reg    <= (cr_reg[0] == '0) && (cr_reg[1] == '0) && (cr_reg[2] == '0);
        end
    end

    // ---- first multiplier rank: |a x b|^2 terms, |a|^2|b|^2, weight numerators
    logic [XMW+MULB-1:0] n2t [3];
    logic [P01W-1:0]     p01;
    logic [WW-1:0]       w [3];
    logic [SQW-1:0]      sq2_d;
    logic [NPT*CW-1:0]   pm_d;
    logic [NPT-1:0]      sg_d;

    for (genvar k = 0; k < 3; k++) begin : g_m1
        cc3_mul #(.WA(XMW), .WB(MULB)) u_n2 (
            .aclk (aclk), .en (adv),
            .a_i (crm_reg[k]), .b_i (MULB'(crm_reg[k])), .p_o (n2t[k])
        );
        // alpha uses |b|^2, beta |c|^2, gamma |a|^2
        cc3_mul #(.WA(SQW), .WB(MULB)) u_w (
            .aclk (aclk), .en (adv),
            .a_i (sq3_reg[(k + 1) % 3]), .b_i (dm_reg[k]), .p_o (w[k])
        );
    end

    cc3_mul #(.WA(SQW), .WB(MULB)) u_p01 (
        .aclk (aclk), .en (adv),
        .a_i (sq3_reg[0]), .b_i (sq3_reg[1]), .p_o (p01)
    );

    cc3_dly #(.W(SQW), .N(MUL_LAT)) u_dsq2 (
        .aclk (aclk), .en (adv), .d_i (sq3_reg[2]), .d_o (sq2_d)
    );
    cc3_dly #(.W(NPT*CW), .N(MUL_LAT)) u_dpm (
        .aclk (aclk), .en (adv), .d_i (pm_reg), .d_o (pm_d)
    );
    cc3_dly #(.W(NPT), .N(ST_M2O - ST_M1)) u_dsg (
        .aclk (aclk), .en (adv), .d_i (sg3), .d_o (sg_d)
    );

    // squared norm of the cross product
    logic [N2W-1:0] n2_reg;
    logic [N2W-1:0] n2_d;

    always_ff @(posedge aclk) begin
        if (adv) begin
            n2_reg <= N2W'(n2t[0]) + N2W'(n2t[1]) + N2W'(n2t[2]);
        end
    end

    cc3_dly #(.W(N2W), .N(ST_T - ST_N2)) u_dn2 (
        .aclk (aclk), .en (adv), .d_i (n2_reg), .d_o (n2_d)
    );

    // ---- second multiplier rank: radius numerator, weights times coordinates
    logic [RNW-1:0]     rn;
    logic [RNW-1:0]     rn_d;
    logic [WW+MULB-1:0] cp [NPT];

    cc3_mul #(.WA(P01W), .WB(MULB)) u_rn (
        .aclk (aclk), .en (adv), .a_i (p01), .b_i (sq2_d), .p_o (rn)
    );

    for (genvar j = 0; j < NPT; j++) begin : g_m2
        cc3_mul #(.WA(WW), .WB(MULB)) u_cp (
            .aclk (aclk), .en (adv),
            .a_i (w[j / 3]), .b_i (MULB'(pm_d[j*CW +: CW])), .p_o (cp[j])
        );
    end

    cc3_dly #(.W(RNW), .N(ST_T - ST_M2O)) u_drn (
        .aclk (aclk), .en (adv), .d_i (rn), .d_o (rn_d)
    );

    // ---- signed sum per axis, then sign and magnitude
    logic [CSW-1:0] csum_w [3];
    logic [CSW-1:0] csum_reg [3];
    logic [CSW-1:0] cabs_w [3];
    logic [CNW-1:0] cmag_reg [3];
    logic [2:0]     cneg_reg;
    logic [CSW-1:0] e;

    always_comb begin
        e = '0;
        for (int k = 0; k < 3; k++) begin
            csum_w[k] = '0;
            for (int i = 0; i < 3; i++) begin
                e         = CSW'(cp[i*3 + k][CPW-1:0]);
                csum_w[k] = csum_w[k] + (sg_d[i*3 + k] ? (~e + 1'b1) : e);
            end
            cabs_w[k] = csum_reg[k][CSW-1] ? (~csum_reg[k] + 1'b1) : csum_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                csum_reg[k] <= csum_w[k];
                cmag_reg[k] <= cabs_w[k][CNW-1:0];
                cneg_reg[k] <= csum_reg[k][CSW-1];
            end
        end
    end

    // ---- dividers
    logic [RQB-1:0] rq;
    logic           rov;
    logic           rov_d;
    logic [CQB-1:0] cq [3];
    logic [2:0]     cov;
    logic [2:0]     cneg_d;

    cc3_div #(.WN(RNW), .WD(RDW), .QB(RQB)) u_rdiv (
        .aclk (aclk), .en (adv),
        .num_i (rn_d), .den_i ({n2_d, 2'b00}), .q_o (rq), .over_o (rov)
    );

    for (genvar k = 0; k < 3; k++) begin : g_cdiv
        cc3_div #(.WN(CNW), .WD(CDW), .QB(CQB)) u_cdiv (
            .aclk (aclk), .en (adv),
            .num_i (cmag_reg[k]), .den_i ({n2_d, 1'b0}), .q_o (cq[k]), .over_o (cov[k])
        );
    end

    cc3_dly #(.W(3), .N(CQB + 1)) u_dcn (
        .aclk (aclk), .en (adv), .d_i (cneg_reg), .d_o (cneg_d)
    );

    // ---- center saturation and sign
    logic [3*OW-1:0] cen_reg;
    logic [3*OW-1:0] cen_d;
    logic [OW-1:0]   cen_w [3];
    logic [OW-1:0]   cmag_w [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (cneg_d[k]) begin
                cmag_w[k] = (cov[k] || (cq[k][OW-1] && (cq[k][OW-2:0] != '0))) ?
                            NEG_MAG : cq[k];
                cen_w[k]  = ~cmag_w[k] + 1'b1;
            end else begin
                cmag_w[k] = cq[k];
                cen_w[k]  = (cov[k] || cq[k][OW-1]) ? POS_MAX : cq[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                cen_reg[k*OW +: OW] <= cen_w[k];
            end
        end
    end

    cc3_dly #(.W(3*OW), .N(ST_SQ - ST_CC)) u_dcen (
        .aclk (aclk), .en (adv), .d_i (cen_reg), .d_o (cen_d)
    );

    // ---- radius square root
    logic [OW-1:0] rroot;
    logic          dg_d;

    cc3_sqrt u_sqrt (
        .aclk (aclk), .en (adv), .x_i (rq), .r_o (rroot)
    );

    cc3_dly #(.W(1), .N(SQ_W / 2)) u_drov (
        .aclk (aclk), .en (adv), .d_i (rov), .d_o (rov_d)
    );
    cc3_dly #(.W(1), .N(ST_SQ - ST_M1)) u_ddg (
        .aclk (aclk), .en (adv), .d_i (dg_reg), .d_o (dg_d)
    );

    // ---- output register: drop every field for collinear points
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= dg_d ? '0 : {cen_d, (rov_d ? RAD_MAX : rroot)};
            m_tuser_reg <= dg_d;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

`ifndef ASSERT_OFF
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("degenerate result with nonzero fields");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline moved during an output stall");

    a_out_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> (m_tvalid == $past(vld_reg[ST_SQ])))
        else $error("output valid out of step with the pipeline");
`endif

endmodule
